### sv/ilir_pkg.sv
// Shared constants, operation codes and cell control type for the indexed list.
`default_nettype none
package ilir_pkg;

  // List size and derived widths
  localparam int DEPTH     = 64;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  // Field widths fixed by the stream format
  localparam int MODE_W    = 2;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  // Signed width that holds a position plus the count
  localparam int RES_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell
  typedef struct packed {
    logic             ins;  // open a slot at idx, shift upper entries up
    logic             rem;  // close the slot at idx, shift upper entries down
    logic [IDX_W-1:0] idx;  // target slot, also the read slot
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/ilir_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
`default_nettype none
module ilir_cell (
  input  logic                       clk,
  input  ilir_pkg::cell_ctrl_t       ctrl,
  input  logic [ilir_pkg::IDX_W-1:0] slot,
  input  logic [ilir_pkg::VAL_W-1:0] new_value,
  input  logic [ilir_pkg::VAL_W-1:0] left_value,   // entry of slot - 1
  input  logic [ilir_pkg::VAL_W-1:0] right_value,  // entry of slot + 1
  output logic [ilir_pkg::VAL_W-1:0] value,
  output logic [ilir_pkg::VAL_W-1:0] read_tap
);
  import ilir_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (slot == ctrl.idx) begin
        value <= new_value;
      end else if (slot > ctrl.idx) begin
        value <= left_value;
      end
    end else if (ctrl.rem && (slot >= ctrl.idx)) begin
      value <= right_value;
    end
  end

  // Only the addressed cell drives its tap; the top ORs all taps.
  assign read_tap = (slot == ctrl.idx) ? value : '0;

endmodule
`default_nettype wire

### sv/indexed_list_insert_remove.sv
// Top level of the indexed list: request decode, count, cell row and result register.
// The result of a request is registered and presented in the cycle after it is accepted.
// One request per cycle while results are taken; s_tready is high whenever the result register
//   is empty or being drained in the same cycle, so a waiting result that is not taken blocks.
// Every cell shifts in the same cycle, so insert and remove cost no more than a read.
// Reset (rst, synchronous, active high) clears the count and the result valid;
//   entry contents are not reset and are only read below the count.
`default_nettype none
module indexed_list_insert_remove (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] position, [39:8] item_value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import ilir_pkg::*;

  // Unpacked request fields
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  item_value;

  assign mode       = s_tuser;
  assign position   = s_tdata[POS_W-1:0];
  assign item_value = s_tdata[POS_W +: VAL_W];

  // Control state
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;

  // Result register
  logic [VAL_W-1:0]     read_value;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] count;

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Index resolution: a negative position counts back from the count.
  logic signed [RES_W-1:0] pos_ext;
  logic signed [RES_W-1:0] cnt_ext;
  logic signed [RES_W-1:0] idx_res;
  logic                    idx_neg;
  logic                    idx_lt_cnt;  // valid for remove and read
  logic                    idx_le_cnt;  // valid for insert
  logic                    full;

  always_comb begin
    pos_ext    = signed'({{(RES_W-POS_W){position[POS_W-1]}}, position});
    cnt_ext    = signed'({{(RES_W-CNT_W){1'b0}}, entry_count});
    idx_res    = position[POS_W-1] ? (pos_ext + cnt_ext) : pos_ext;
    idx_neg    = idx_res[RES_W-1];
    idx_lt_cnt = !idx_neg && (idx_res <  cnt_ext);
    idx_le_cnt = !idx_neg && (idx_res <= cnt_ext);
    full       = (entry_count == CNT_W'(DEPTH));
  end

  // Cell row
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] cell_value [DEPTH];
  logic [VAL_W-1:0] cell_tap   [DEPTH];
  logic [VAL_W-1:0] tap_or;

  // Decode of the request
  logic [STAT_W-1:0] status_next;
  logic [VAL_W-1:0]  read_value_next;
  logic              read_ok;

  always_comb begin
    ctrl             = '0;
    ctrl.idx         = idx_res[IDX_W-1:0];
    status_next      = ST_DONE;
    read_ok          = 1'b0;
    entry_count_next = entry_count;
    case (mode)
      MODE_APPEND: begin
        // Append is an insert at the current count.
        ctrl.idx = entry_count[IDX_W-1:0];
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins         = accept;
          entry_count_next = entry_count + 1'b1;
        end
      end
      MODE_INSERT: begin
        if (!idx_le_cnt) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins         = accept;
          entry_count_next = entry_count + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (!idx_lt_cnt) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.rem         = accept;
          entry_count_next = entry_count - 1'b1;
        end
      end
      MODE_READ: begin
        if (!idx_lt_cnt) begin
          status_next = ST_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // A failed read or any other operation returns zero
  assign read_value_next = read_ok ? tap_or : '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VAL_W-1:0] left_in;
      logic [VAL_W-1:0] right_in;
      // The ends of the chain: cell 0 never takes a left entry, the last
      // cell's upper neighbor is past the list and holds nothing of use.
      if (gi == 0) begin : g_lo
        assign left_in = item_value;
      end else begin : g_lo_n
        assign left_in = cell_value[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_hi
        assign right_in = cell_value[gi];
      end else begin : g_hi_n
        assign right_in = cell_value[gi+1];
      end
      ilir_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .slot        (IDX_W'(gi)),
        .new_value   (item_value),
        .left_value  (left_in),
        .right_value (right_in),
        .value       (cell_value[gi]),
        .read_tap    (cell_tap[gi])
      );
    end
  endgenerate

  // Gather the addressed cell's entry
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // Count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= read_value_next;
      status     <= status_next;
      count      <= CNT_OUT_W'(entry_count_next);
    end
  end

  assign m_tdata = {1'b0, count, read_value};
  assign m_tuser = status;

endmodule
`default_nettype wire

### dv/indexed_list_insert_remove_tb.sv
// Self-checking testbench for the indexed list block: directed, full-list and random requests.
module indexed_list_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  // One result as the block should return it
  typedef struct packed {
    logic [VAL_W-1:0]     read_value;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] position, [39:8] item_value
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] read_value, [38:32] count, [39] zero
  logic [1:0]  m_tuser;        // [1:0] status

  // Shadow copy of the list, updated as each request is accepted
  logic [VAL_W-1:0] list_mem [DEPTH];
  int               list_len = 0;
  bit               list_growing = 1'b1;

  list_result_t expected_results [$];
  int           error_count = 0;

  // Idle percentages, changed per test
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  indexed_list_insert_remove dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the shadow list and return the result it must give.
  // Position is resolved after sign extension; negative counts back from the length.
  function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] op,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t res;
    int           slot;
    res  = '0;
    slot = int'(pos);
    if (slot < 0) slot += list_len;
    case (op)
      MODE_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      MODE_INSERT: begin
        // range fault wins over full
        if (slot < 0 || slot > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = val;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (slot < 0 || slot >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        // read; a failed read returns zero
        if (slot < 0 || slot >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_mem[slot];
        end
      end
    endcase
    res.count = list_len[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Present one request at the falling edge, hold it until accepted, then predict.
  // Returns at a falling edge with tvalid still high, so back-to-back requests
  // never lower and raise tvalid in the same step.
  task automatic send_request(input logic [MODE_W-1:0] op,
                              input logic signed [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(apply_list_op(op, pos, val));
    @(negedge clk);
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Receiver: tready decided fresh at every falling edge
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker: compare each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h status=%0d", m_tdata, m_tuser));
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.read_value)
          report_mismatch($sformatf("read_value got %h want %h", m_tdata[31:0],
                                    want.read_value));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
        if (m_tdata[38:32] !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", m_tdata[38:32], want.count));
        if (m_tdata[39] !== 1'b0)
          report_mismatch($sformatf("pad bit got %b want 0", m_tdata[39]));
      end
    end
  end

  // Corners: empty list faults, extreme values, inserts at both ends,
  // reads and removes at the first, last and just-outside indexes.
  task automatic test_edge_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(MODE_READ,    0,  32'h0);          // read on empty list
    send_request(MODE_REMOVE,  -1, 32'h0);          // remove on empty list
    send_request(MODE_INSERT,  1,  32'h1);          // insert past the end
    send_request(MODE_INSERT,  -1, 32'h1);          // negative resolves below zero
    send_request(MODE_INSERT,  0,  32'h7FFF_FFFF);  // index 0 accepted
    send_request(MODE_APPEND,  64, 32'h8000_0000);  // append ignores position
    send_request(MODE_APPEND,  -64, 32'hFFFF_FFFF);
    send_request(MODE_APPEND,  0,  32'h0);
    send_request(MODE_INSERT,  4,  32'h5555_5555);  // insert at count
    send_request(MODE_INSERT,  -1, 32'hAAAA_AAAA);
    send_request(MODE_INSERT,  2,  32'h1234_5678);
    send_request(MODE_READ,    0,  32'hFFFF_FFFF);
    send_request(MODE_READ,    -1, 32'h0);
    send_request(MODE_READ,    6,  32'h0);
    send_request(MODE_READ,    7,  32'h0);          // one past the last entry
    send_request(MODE_READ,    -7, 32'h0);
    send_request(MODE_READ,    -8, 32'h0);          // one before the first entry
    send_request(MODE_REMOVE,  0,  32'h0);
    send_request(MODE_REMOVE,  -1, 32'h0);
    send_request(MODE_REMOVE,  2,  32'h0);
    send_request(MODE_REMOVE,  64, 32'h0);
    send_request(MODE_REMOVE,  -64, 32'h0);
    send_request(MODE_READ,    64, 32'h0);
    send_request(MODE_READ,    -64, 32'h0);
    drain_results();
  endtask

  // Fill to DEPTH, hit the full faults (and range-plus-full), then empty it.
  task automatic test_full_list();
    int slot;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (list_len < DEPTH) send_request(MODE_APPEND, 0, $urandom());
    send_request(MODE_APPEND, 0,    32'h1);
    send_request(MODE_INSERT, 0,    32'h2);
    send_request(MODE_INSERT, 64,   32'h3);
    send_request(MODE_INSERT, -64,  32'h4);
    // out of range while full: range status must win
    send_request(MODE_INSERT, 65,   32'h5);
    send_request(MODE_INSERT, -65,  32'h6);
    send_request(MODE_INSERT, 127,  32'h7);
    send_request(MODE_INSERT, -128, 32'h8);
    send_request(MODE_READ,   63,   32'h0);
    send_request(MODE_READ,   -64,  32'h0);
    send_request(MODE_READ,   64,   32'h0);
    send_request(MODE_REMOVE, -128, 32'h0);
    send_request(MODE_REMOVE, -1,   32'h0);
    send_request(MODE_INSERT, -1,   $urandom());
    send_request(MODE_APPEND, 0,    32'h9);
    while (list_len > 0) begin
      slot = $urandom_range(list_len - 1, 0);
      if ($urandom_range(3) == 0) send_request(MODE_READ, POS_W'(slot), $urandom());
      send_request(MODE_REMOVE, POS_W'(slot), $urandom());
    end
    drain_results();
  endtask

  // Random mix that drifts between growing and shrinking, so the length sweeps
  // the whole range. Most indexes are legal; about one in ten is noise.
  task automatic run_random_ops(input int n_ops);
    int               pick;
    int               hi;
    int               slot;
    int               pos;
    logic [MODE_W-1:0] op;
    logic [VAL_W-1:0]  val;
    for (int k = 0; k < n_ops; k++) begin
      if (list_len == DEPTH) list_growing = 1'b0;
      else if (list_len == 0) list_growing = 1'b1;
      else if ($urandom_range(31) == 0) list_growing = !list_growing;

      pick = $urandom_range(99);
      if (list_growing)
        op = (pick < 35) ? MODE_APPEND : (pick < 70) ? MODE_INSERT :
             (pick < 85) ? MODE_REMOVE : MODE_READ;
      else
        op = (pick < 10) ? MODE_APPEND : (pick < 25) ? MODE_INSERT :
             (pick < 70) ? MODE_REMOVE : MODE_READ;

      hi = (op == MODE_INSERT) ? list_len : list_len - 1;
      if (hi < 0 || $urandom_range(9) == 0) begin
        pos = int'($urandom_range(128)) - 64;
      end else begin
        slot = $urandom_range(hi, 0);
        pos  = $urandom_range(1) ? slot - list_len : slot;
      end

      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: val = 32'h0000_0000;
          1: val = 32'hFFFF_FFFF;
          2: val = 32'h7FFF_FFFF;
          default: val = 32'h8000_0000;
        endcase
      end else begin
        val = $urandom();
      end
      send_request(op, POS_W'(pos), val);
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_ops(70);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    run_random_ops(70);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    run_random_ops(70);
  endtask

  task automatic test_mixed_idling();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random_ops(70);
    // finish with a stretch where nothing idles
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_ops(30);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_cases();
    test_full_list();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    // a few more cycles to catch any stray result
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
